### rtl/core/slcan_pkg.sv
// ----------------------------------------------------------------------------
// SLCAN bridge package
// Shared constants and character helpers for the SLCAN ASCII bridge.
// ----------------------------------------------------------------------------
package slcan_pkg;

  localparam int unsigned LineDepth = 64;
  localparam int unsigned LineAw    = $clog2(LineDepth);

  localparam logic [1:0] ActHost = 2'd0;
  localparam logic [1:0] ActRx   = 2'd1;
  localparam logic [1:0] ActEcho = 2'd2;
  localparam logic [1:0] ActTick = 2'd3;

  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChBell = 8'h07;

  localparam logic [28:0] StdIdMax = 29'h7ff;

  // Hex digit value of an ASCII character; anything else reads as zero.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

  // Upper-case ASCII hex digit.
  function automatic logic [7:0] hex_chr(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h37 + 8'(v));
  endfunction

endpackage

### rtl/core/slcan_ascii_can_bridge.sv
// ----------------------------------------------------------------------------
// SLCAN ASCII CAN bridge
// Line-based SLCAN command interpreter and CAN frame to text formatter.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  input   | in        | in_valid_i/in_stall_o   | action, host byte, frame, stamp
//  output  | out       | out_valid_o/out_stall_i | char, tx frame, start, last
//
// An item is held in input registers and worked off by a small sequencer.
// A host byte other than CR is written to the line store. A CR first parses
// the line out of the line store, one character per cycle through the single
// read port, then decodes the command and emits its replies one per
// cycle while the output is not stalled. A received frame emits up to 31
// characters, one per cycle while the output is not stalled, from a shared
// nibble selector. Output results sit in one output register; a stall simply
// holds it. While a transmit frame waits at the output the input is stalled,
// since its fields are taken straight from the parse registers.
// Reset clears all control state and the line store contents read as zero
// through per-entry valid bits; the block takes items right after reset.

module slcan_ascii_can_bridge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  host_char_i,
  input  logic        start_ok_i,
  input  logic [28:0] frame_id_i,
  input  logic        frame_ext_i,
  input  logic        frame_rtr_i,
  input  logic [3:0]  frame_dlc_i,
  input  logic [63:0] frame_data_i,
  input  logic [15:0] timestamp_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        char_valid_o,
  output logic        tx_frame_valid_o,
  output logic [28:0] tx_id_o,
  output logic        tx_ext_o,
  output logic        tx_rtr_o,
  output logic [3:0]  tx_dlc_o,
  output logic [63:0] tx_data_o,
  output logic        start_request_o,
  output logic [3:0]  start_bitrate_o,
  output logic        last_o
);
  import slcan_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StStore, StRead, StCmd, StEmit
  } state_e;

  // Reply kinds for the emit sequencer.
  typedef enum logic [2:0] {
    RpStr, RpRx, RpTx, RpStart
  } reply_e;

  state_e state_q;
  reply_e kind_q;

  logic [7:0]        mem_q [LineDepth];
  logic [LineDepth-1:0] vld_q;
  logic [LineAw-1:0] idx_q;
  logic [2:0]        idle_q;
  logic              open_q, txok_q, brset_q, ts_q;
  logic [3:0]        brc_q;

  // Latched item.
  logic [7:0]  hch_q;
  logic        sok_q;
  logic [28:0] fid_q;
  logic        fext_q, frtr_q;
  logic [3:0]  fdlc_q;
  logic [63:0] fdat_q;
  logic [15:0] fts_q;

  // Line read and parse state.
  logic [4:0]  rpos_q;
  logic [7:0]  rdat_q;
  logic [7:0]  c0_q, c1_q;
  logic [31:0] pid_q;
  logic [3:0]  pdlc_q;
  logic [63:0] pdat_q;

  // Emit sequencing: a string of up to 6 chars, or formatted frame text.
  logic [47:0] str_q;
  logic [2:0]  slen_q;
  logic [4:0]  epos_q;

  logic        ov_q;
  logic [7:0]  och_q;
  logic        ocv_q, otx_q, osr_q, olast_q;
  logic [3:0]  obr_q;

  assign in_stall_o      = (state_q != StIdle) || (ov_q && otx_q);
  assign out_valid_o     = ov_q;
  assign out_char_o      = och_q;
  assign char_valid_o    = ocv_q;
  assign tx_frame_valid_o = otx_q;
  assign tx_id_o         = otx_q ? pid_q[28:0] : 29'd0;
  assign tx_ext_o        = otx_q & (c0_q == "T" || c0_q == "R");
  assign tx_rtr_o        = otx_q & (c0_q == "r" || c0_q == "R");
  assign tx_dlc_o        = otx_q ? pdlc_q : 4'd0;
  assign tx_data_o       = otx_q ? pdat_q : 64'd0;
  assign start_request_o = osr_q;
  assign start_bitrate_o = osr_q ? obr_q : 4'd0;
  assign last_o          = olast_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ov_q || !out_stall_i;

  logic ext_cmd, rtr_cmd;
  assign ext_cmd = (c0_q == "T" || c0_q == "R");
  assign rtr_cmd = (c0_q == "r" || c0_q == "R");

  // Position of the dlc digit in the line.
  logic [4:0] dlc_pos;
  assign dlc_pos = ext_cmd ? 5'd9 : 5'd4;

  // Read position at which the parser stops. A frame line is read up to one
  // past the dlc digit; once the dlc is known the data digits are added.
  logic [4:0] need;
  always_comb begin
    need = 5'd2;
    if (c0_q inside {"t", "r", "T", "R"}) begin
      need = dlc_pos + 5'd2;
      if (!rtr_cmd && pdlc_q <= 4'd8 && rpos_q >= need)
        need = dlc_pos + 5'd1 + 5'({pdlc_q, 1'b0});
    end
  end

  // Decoded command: the reply it gives and whether it gives one at all.
  logic        id_ok;
  reply_e      cmd_kind;
  logic [47:0] cmd_str;
  logic [2:0]  cmd_slen;
  logic        cmd_reply;
  assign id_ok = ext_cmd ? (pid_q <= 32'h1fffffff) : (pid_q <= 32'(StdIdMax));

  always_comb begin
    cmd_kind  = RpStr;
    cmd_str   = {ChBell, 40'd0};
    cmd_slen  = 3'd1;
    cmd_reply = 1'b1;
    case (c0_q)
      "t", "r", "T", "R": begin
        if (txok_q && pdlc_q <= 4'd8 && id_ok) cmd_kind = RpTx;
      end
      "O": begin
        if (brset_q && !open_q) cmd_kind = RpStart;
      end
      "L", "l": begin
        if (brset_q && !open_q) cmd_str = {ChCr, 40'd0};
      end
      "C": begin
        if (open_q) cmd_str = {ChCr, 40'd0};
      end
      "F": begin
        cmd_str  = {"F00", ChCr, 16'd0};
        cmd_slen = 3'd4;
      end
      "S": begin
        if (!open_q && (c1_q inside {["0":"8"]})) cmd_str = {ChCr, 40'd0};
      end
      "U", "X": cmd_str = {ChCr, 40'd0};
      "P", "A", "W": cmd_str = {ChBell, 40'd0};
      "Z": begin
        if (!open_q && (c1_q inside {"0", "1"})) cmd_str = {ChCr, 40'd0};
      end
      "v", "V": begin
        cmd_str  = {"V1220", ChCr};
        cmd_slen = 3'd6;
      end
      "N": begin
        cmd_str  = {"N1234", ChCr};
        cmd_slen = 3'd6;
      end
      default: cmd_reply = 1'b0;
    endcase
  end

  // Received-frame text: character at position epos_q.
  logic [4:0] id_digits;
  logic [7:0] rx_ch;
  logic [4:0] dstart, tstart;
  logic [3:0] ndat;
  logic [4:0] rel;
  logic [3:0] nib;
  always_comb begin
    id_digits = fext_q ? 5'd8 : 5'd3;
    ndat      = frtr_q ? 4'd0 : ((fdlc_q > 4'd8) ? 4'd8 : fdlc_q);
    dstart    = id_digits + 5'd2;
    tstart    = dstart + 5'({ndat, 1'b0});
    rel       = 5'd0;
    nib       = 4'd0;
    rx_ch     = ChCr;
    if (epos_q == 5'd0) begin
      rx_ch = fext_q ? (frtr_q ? "R" : "T") : (frtr_q ? "r" : "t");
    end else if (epos_q <= id_digits) begin
      rel = id_digits - epos_q;
      nib = 4'(fid_q >> {rel[2:0], 2'b00});
      rx_ch = hex_chr(nib);
    end else if (epos_q == id_digits + 5'd1) begin
      rx_ch = hex_chr(fdlc_q);
    end else if (epos_q < tstart) begin
      rel = epos_q - dstart;
      nib = 4'(fdat_q >> {rel[3:1], !rel[0], 2'b00});
      rx_ch = hex_chr(nib);
    end else if (ts_q && epos_q < tstart + 5'd4) begin
      rel = 5'd3 - (epos_q - tstart);
      nib = 4'(fts_q >> {rel[1:0], 2'b00});
      rx_ch = hex_chr(nib);
    end
  end

  logic [LineAw-1:0] cr_next;
  assign cr_next = idx_q + LineAw'(1);

  always_ff @(posedge clk_i) begin
    rdat_q <= vld_q[LineAw'(rpos_q)] ? mem_q[LineAw'(rpos_q)] : 8'd0;
    if (state_q == StStore) begin
      mem_q[idx_q] <= hch_q;
    end else if (state_q == StCmd && idx_q != LineAw'(LineDepth - 1)) begin
      mem_q[cr_next] <= 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= RpStr;
      vld_q   <= '0;
      idx_q   <= '0;
      idle_q  <= '0;
      open_q  <= 1'b0;
      txok_q  <= 1'b0;
      brset_q <= 1'b0;
      ts_q    <= 1'b0;
      brc_q   <= '0;
      ov_q    <= 1'b0;
      ocv_q   <= 1'b0;
      otx_q   <= 1'b0;
      osr_q   <= 1'b0;
      olast_q <= 1'b0;
      rpos_q  <= '0;
      epos_q  <= '0;
    end else begin
      if (state_q == StEmit && out_free) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            hch_q <= host_char_i; sok_q <= start_ok_i;
            fid_q <= frame_id_i; fext_q <= frame_ext_i; frtr_q <= frame_rtr_i;
            fdlc_q <= frame_dlc_i; fdat_q <= frame_data_i;
            fts_q <= timestamp_ms_i;
            epos_q <= '0;
            case (action_i)
              ActHost: begin
                if (idle_q > 3'd5) idx_q <= '0;
                idle_q  <= '0;
                state_q <= StStore;
              end
              ActRx: begin
                if (open_q) begin
                  kind_q  <= RpRx;
                  state_q <= StEmit;
                end
              end
              ActEcho: begin
                str_q   <= {(frame_ext_i ? "Z" : "z"), ChCr, 32'd0};
                slen_q  <= 3'd2;
                kind_q  <= RpStr;
                state_q <= StEmit;
              end
              default: begin
                if (idle_q < 3'd6) idle_q <= idle_q + 3'd1;
              end
            endcase
          end
        end
        StStore: begin
          vld_q[idx_q] <= 1'b1;
          if (hch_q == ChCr) begin
            rpos_q  <= '0;
            pid_q   <= '0;
            pdlc_q  <= '0;
            pdat_q  <= '0;
            state_q <= StRead;
          end else begin
            idx_q   <= idx_q + LineAw'(1);
            state_q <= StIdle;
          end
        end
        StRead: begin
          // rdat_q holds the character at rpos_q - 1 from the prior cycle.
          if (rpos_q != 5'd0) begin
            if (rpos_q == 5'd1) c0_q <= rdat_q;
            else if (rpos_q == 5'd2) c1_q <= rdat_q;
            if (rpos_q >= 5'd2 && rpos_q <= dlc_pos) begin
              pid_q <= {pid_q[27:0], hex_val(rdat_q)};
            end else if (rpos_q == dlc_pos + 5'd1) begin
              pdlc_q <= hex_val(rdat_q);
            end else if (rpos_q > dlc_pos + 5'd1 && !rtr_cmd &&
                         rpos_q <= dlc_pos + 5'd1 + 5'({pdlc_q, 1'b0})) begin
              pdat_q <= pdat_q | (64'(hex_val(rdat_q)) <<
                {rpos_q - dlc_pos - 5'd2 ^ 5'd1, 2'b00});
            end
          end
          if (rpos_q != 5'd0 && rpos_q >= need) begin
            state_q <= StCmd;
          end else begin
            rpos_q <= rpos_q + 5'd1;
          end
          if (rpos_q == 5'd1) c1_q <= 8'd0;
        end
        StCmd: begin
          if (idx_q != LineAw'(LineDepth - 1)) vld_q[cr_next] <= 1'b1;
          idx_q   <= '0;
          kind_q  <= cmd_kind;
          slen_q  <= cmd_slen;
          str_q   <= cmd_str;
          state_q <= cmd_reply ? StEmit : StIdle;
          case (c0_q)
            "O": begin
              if (brset_q && !open_q && sok_q) begin
                open_q <= 1'b1;
                txok_q <= 1'b1;
              end
            end
            "L", "l": begin
              if (brset_q && !open_q) begin
                open_q <= 1'b1;
                txok_q <= (c0_q == "l");
              end
            end
            "C": begin
              if (open_q) begin
                open_q <= 1'b0; txok_q <= 1'b0; brc_q <= '0;
                ts_q <= 1'b0; brset_q <= 1'b0;
              end
            end
            "S": begin
              if (!open_q && (c1_q inside {["0":"8"]})) begin
                brset_q <= 1'b1;
                brc_q   <= 4'(c1_q - "0");
              end
            end
            "Z": begin
              if (!open_q && (c1_q inside {"0", "1"})) ts_q <= c1_q[0];
            end
            default: ;
          endcase
        end
        StEmit: begin
          if (out_free) begin
            case (kind_q)
              RpRx: begin
                och_q   <= rx_ch;
                ocv_q   <= 1'b1;
                otx_q   <= 1'b0;
                osr_q   <= 1'b0;
                olast_q <= (rx_ch == ChCr) && (epos_q != 5'd0);
                epos_q  <= epos_q + 5'd1;
                if ((rx_ch == ChCr) && (epos_q != 5'd0)) state_q <= StIdle;
              end
              RpTx: begin
                och_q <= 8'd0; ocv_q <= 1'b0; otx_q <= 1'b1; osr_q <= 1'b0;
                olast_q <= 1'b1;
                state_q <= StIdle;
              end
              RpStart: begin
                och_q <= sok_q ? ChCr : ChBell; ocv_q <= 1'b1; otx_q <= 1'b0;
                osr_q <= 1'b1; obr_q <= brc_q; olast_q <= 1'b1;
                state_q <= StIdle;
              end
              default: begin
                och_q   <= str_q[47:40];
                ocv_q   <= 1'b1;
                otx_q   <= 1'b0;
                osr_q   <= 1'b0;
                str_q   <= {str_q[39:0], 8'd0};
                slen_q  <= slen_q - 3'd1;
                olast_q <= (slen_q == 3'd1);
                if (slen_q == 3'd1) state_q <= StIdle;
              end
            endcase
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q) else $error("result dropped");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> in_stall_o) else $error("accept while busy");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(otx_q && ocv_q)) else $error("frame with char");
`endif

endmodule

### test/tb_slcan_ascii_can_bridge.sv
// ----------------------------------------------------------------------------
// SLCAN ASCII CAN bridge testbench
// Drives host bytes, received frames, transmit echoes and one-second ticks
// into the bridge with random gaps and output stalls. A behavioral model of
// the command interpreter predicts every reply character, transmit frame
// and start request, and a monitor checks them in order, field by field.
// ----------------------------------------------------------------------------
module tb_slcan_ascii_can_bridge;
  import slcan_pkg::*;

  // One input item as offered to the bridge. The hold flag makes the
  // driver wait until every expected result has come out before offering it.
  typedef struct {
    logic [1:0]  action;
    logic [7:0]  host_char;
    logic        start_ok;
    logic [28:0] frame_id;
    logic        frame_ext;
    logic        frame_rtr;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic [15:0] timestamp_ms;
    bit          hold;
  } bridge_item_t;

  // One result item: a character, a transmit frame or a start request.
  typedef struct {
    logic [7:0]  out_char;
    logic        char_valid;
    logic        tx_frame_valid;
    logic [28:0] tx_id;
    logic        tx_ext;
    logic        tx_rtr;
    logic [3:0]  tx_dlc;
    logic [63:0] tx_data;
    logic        start_request;
    logic [3:0]  start_bitrate;
    logic        last;
  } bridge_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ActHost;
  logic [7:0]  host_char_i = '0;
  logic        start_ok_i = 1'b0;
  logic [28:0] frame_id_i = '0;
  logic        frame_ext_i = 1'b0;
  logic        frame_rtr_i = 1'b0;
  logic [3:0]  frame_dlc_i = '0;
  logic [63:0] frame_data_i = '0;
  logic [15:0] timestamp_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        char_valid_o;
  logic        tx_frame_valid_o;
  logic [28:0] tx_id_o;
  logic        tx_ext_o;
  logic        tx_rtr_o;
  logic [3:0]  tx_dlc_o;
  logic [63:0] tx_data_o;
  logic        start_request_o;
  logic [3:0]  start_bitrate_o;
  logic        last_o;

  slcan_ascii_can_bridge dut (.*);

  always #1 clk_i = ~clk_i;

  // Items waiting to be offered, and replies the model says must come out.
  bridge_item_t  pending_q[$];
  bridge_reply_t reply_q[$];
  bridge_reply_t reply_buf[$];

  int error_count = 0;
  int items_sent = 0;
  int replies_seen = 0;
  int frames_sent = 0;

  // ---------------------------------------------------------------------------
  // Behavioral model of the bridge: its own line store, line position, idle
  // timer and port state.
  // ---------------------------------------------------------------------------
  logic [7:0] line_mem[LineDepth];
  int         line_pos = 0;
  int         idle_secs = 0;
  bit         is_open = 0;
  bit         tx_allowed = 0;
  bit         rate_valid = 0;
  logic [3:0] rate_code = '0;
  bit         stamps_on = 0;

  initial foreach (line_mem[i]) line_mem[i] = '0;

  function automatic logic [7:0] line_at(int pos);
    return line_mem[pos % LineDepth];
  endfunction

  // Hex field of n digits at a fixed line position; stray characters read as 0.
  function automatic logic [31:0] hex_field(int pos, int n);
    logic [31:0] acc;
    logic [7:0]  c;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      c = line_at(pos + i);
      acc = acc << 4;
      if (c inside {["0":"9"]}) acc[3:0] = c - "0";
      else if (c inside {["A":"F"]}) acc[3:0] = c - "A" + 10;
      else if (c inside {["a":"f"]}) acc[3:0] = c - "a" + 10;
    end
    return acc;
  endfunction

  function automatic void emit_char(logic [7:0] c);
    bridge_reply_t r;
    r = '{default: '0};
    r.out_char = c;
    r.char_valid = 1'b1;
    reply_buf.push_back(r);
  endfunction

  function automatic void emit_text(string s);
    for (int i = 0; i < s.len(); i++) emit_char(s[i]);
  endfunction

  function automatic void emit_nibble(logic [3:0] v);
    string digits;
    digits = "0123456789ABCDEF";
    emit_char(digits[v]);
  endfunction

  function automatic void emit_hex_byte(logic [7:0] v);
    emit_nibble(v[7:4]);
    emit_nibble(v[3:0]);
  endfunction

  // Parses a t/T/r/R line. Returns 0 when the id or the length is out of range.
  function automatic bit parse_tx_frame();
    logic [7:0]    c;
    bit            ext, rtr;
    int            pos;
    logic [31:0]   id, dlc;
    logic [63:0]   data;
    bridge_reply_t r;
    c = line_at(0);
    ext = (c == "T" || c == "R");
    rtr = (c == "r" || c == "R");
    if (!ext) begin
      id = hex_field(1, 3);
      pos = 4;
      if (id > 32'h7ff) return 0;
    end else begin
      id = hex_field(1, 8);
      pos = 9;
      if (id > 32'h1fffffff) return 0;
    end
    dlc = hex_field(pos, 1);
    pos++;
    if (dlc > 8) return 0;
    data = '0;
    if (!rtr)
      for (int i = 0; i < dlc; i++)
        data |= 64'(hex_field(pos + 2 * i, 2)) << (8 * i);
    r = '{default: '0};
    r.tx_frame_valid = 1'b1;
    r.tx_id = id[28:0];
    r.tx_ext = ext;
    r.tx_rtr = rtr;
    r.tx_dlc = dlc[3:0];
    r.tx_data = data;
    reply_buf.push_back(r);
    frames_sent++;
    return 1;
  endfunction

  // Runs the command held at the start of the line store.
  function automatic void run_line(logic start_ok);
    logic [7:0]    cmd, arg;
    bridge_reply_t r;
    cmd = line_at(0);
    arg = line_at(1);
    case (cmd)
      "t", "r", "T", "R": begin
        if (!(tx_allowed && parse_tx_frame())) emit_char(ChBell);
      end
      "O": begin
        if (rate_valid && !is_open) begin
          r = '{default: '0};
          r.char_valid = 1'b1;
          r.start_request = 1'b1;
          r.start_bitrate = rate_code;
          r.out_char = start_ok ? ChCr : ChBell;
          reply_buf.push_back(r);
          if (start_ok) begin
            is_open = 1;
            tx_allowed = 1;
          end
        end else begin
          emit_char(ChBell);
        end
      end
      "L", "l": begin
        if (rate_valid && !is_open) begin
          is_open = 1;
          tx_allowed = (cmd == "l");
          emit_char(ChCr);
        end else begin
          emit_char(ChBell);
        end
      end
      "C": begin
        if (is_open) begin
          is_open = 0;
          tx_allowed = 0;
          rate_code = '0;
          stamps_on = 0;
          rate_valid = 0;
          emit_char(ChCr);
        end else begin
          emit_char(ChBell);
        end
      end
      "F": emit_text("F00\r");
      "S": begin
        if (is_open || arg < "0" || arg > "8") begin
          emit_char(ChBell);
        end else begin
          rate_valid = 1;
          rate_code = 4'(arg - "0");
          emit_char(ChCr);
        end
      end
      "U", "X": emit_char(ChCr);
      "P", "A", "W": emit_char(ChBell);
      "Z": begin
        if (is_open || (arg != "0" && arg != "1")) begin
          emit_char(ChBell);
        end else begin
          stamps_on = (arg == "1");
          emit_char(ChCr);
        end
      end
      "v", "V": emit_text("V1220\r");
      "N": emit_text("N1234\r");
      default: ;
    endcase
  endfunction

  // Works out every result of one accepted item and queues them in order.
  function automatic void predict_item(bridge_item_t it);
    int n;
    reply_buf.delete();
    case (it.action)
      ActHost: begin
        if (idle_secs > 5) line_pos = 0;
        idle_secs = 0;
        line_mem[line_pos] = it.host_char;
        if (it.host_char == ChCr) begin
          run_line(it.start_ok);
          // A terminator past the end of the store is dropped.
          if (line_pos + 1 < LineDepth) line_mem[line_pos + 1] = '0;
          line_pos = 0;
        end else begin
          line_pos = (line_pos + 1) % LineDepth;
        end
      end
      ActRx: begin
        if (is_open) begin
          if (!it.frame_ext) begin
            emit_char(it.frame_rtr ? "r" : "t");
            emit_nibble(it.frame_id[11:8]);
            emit_hex_byte(it.frame_id[7:0]);
          end else begin
            emit_char(it.frame_rtr ? "R" : "T");
            emit_hex_byte({3'b000, it.frame_id[28:24]});
            emit_hex_byte(it.frame_id[23:16]);
            emit_hex_byte(it.frame_id[15:8]);
            emit_hex_byte(it.frame_id[7:0]);
          end
          emit_nibble(it.frame_dlc);
          if (!it.frame_rtr) begin
            n = (it.frame_dlc > 8) ? 8 : it.frame_dlc;
            for (int i = 0; i < n; i++) emit_hex_byte(it.frame_data[8 * i +: 8]);
          end
          if (stamps_on) begin
            emit_hex_byte(it.timestamp_ms[15:8]);
            emit_hex_byte(it.timestamp_ms[7:0]);
          end
          emit_char(ChCr);
        end
      end
      ActEcho: emit_text(it.frame_ext ? "Z\r" : "z\r");
      default: if (idle_secs < 6) idle_secs++;
    endcase
    if (reply_buf.size() > 0) reply_buf[$].last = 1'b1;
    foreach (reply_buf[i]) reply_q.push_back(reply_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  function automatic bridge_item_t blank_item(logic [1:0] act);
    bridge_item_t it;
    it = '{default: '0};
    it.action = act;
    // Fields that the action ignores still carry random values.
    it.host_char = $urandom_range(0, 255);
    it.frame_id = $urandom;
    it.frame_ext = $urandom_range(0, 1);
    it.frame_rtr = $urandom_range(0, 1);
    it.frame_dlc = $urandom_range(0, 15);
    it.frame_data = {$urandom, $urandom};
    it.timestamp_ms = $urandom_range(0, 65535);
    it.start_ok = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic void queue_byte(logic [7:0] c, logic start_ok = 1'b1);
    bridge_item_t it;
    it = blank_item(ActHost);
    it.host_char = c;
    it.start_ok = start_ok;
    pending_q.push_back(it);
  endfunction

  // A whole command line followed by its carriage return.
  function automatic void queue_line(string s, logic start_ok = 1'b1);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], start_ok);
    queue_byte(ChCr, start_ok);
  endfunction

  function automatic void queue_rx(logic [28:0] id, logic ext, logic rtr,
                                   logic [3:0] dlc, logic [63:0] data);
    bridge_item_t it;
    it = blank_item(ActRx);
    it.frame_id = id;
    it.frame_ext = ext;
    it.frame_rtr = rtr;
    it.frame_dlc = dlc;
    it.frame_data = data;
    pending_q.push_back(it);
  endfunction

  function automatic void queue_simple(logic [1:0] act);
    pending_q.push_back(blank_item(act));
  endfunction

  // One character of a pool, as a string.
  function automatic string char_at(string pool, int i);
    return pool.substr(i, i);
  endfunction

  function automatic string rand_hex(int n);
    string pool, s;
    pool = "0123456789ABCDEFabcdef";
    s = "";
    for (int i = 0; i < n; i++) begin
      // Now and then a digit is replaced by a character that is not hex.
      if ($urandom_range(0, 30) == 0) s = {s, "G"};
      else s = {s, char_at(pool, $urandom_range(0, 21))};
    end
    return s;
  endfunction

  // A frame command with random content; the length digit sometimes exceeds 8.
  function automatic string rand_frame_line();
    string s;
    int    dlc;
    case ($urandom_range(0, 3))
      0: s = {"t", rand_hex(3)};
      1: s = {"r", rand_hex(3)};
      2: s = {"T", $urandom_range(0, 3) == 0 ? rand_hex(8)
                   : {char_at("01", $urandom_range(0, 1)), rand_hex(7)}};
      default: s = {"R", rand_hex(8)};
    endcase
    dlc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    s = {s, char_at("0123456789ABCDEF", dlc)};
    return {s, rand_hex(dlc > 8 ? 16 : 2 * dlc)};
  endfunction

  function automatic void build_random(int target);
    string simple_cmds;
    simple_cmds = "OLlCFUXPAWvVNqx";
    while (pending_q.size() < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: queue_line(rand_frame_line());
        5: queue_line({"S", char_at("0123456789s", $urandom_range(0, 10))});
        6: queue_line({"Z", char_at("012a", $urandom_range(0, 3))});
        7, 8: queue_line(char_at(simple_cmds, $urandom_range(0, 14)),
                         $urandom_range(0, 3) != 0);
        9: begin
          // Open with the controller refusing or accepting the start.
          queue_line({"S", char_at("012345678", $urandom_range(0, 8))});
          queue_line("O", $urandom_range(0, 1));
        end
        10: queue_line("C");
        11, 12, 13: queue_rx($urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 15), {$urandom, $urandom});
        14: queue_simple(ActEcho);
        15: queue_simple(ActTick);
        16: begin
          // A half line followed by ticks that sometimes let it go stale, then a new command.
          queue_byte("t");
          queue_byte("1");
          repeat ($urandom_range(4, 8)) queue_simple(ActTick);
          queue_line("V");
        end
        17: queue_byte($urandom_range(0, 255));
        default: begin
          pending_q[$].hold = ($urandom_range(0, 9) == 0);
          queue_line("F");
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers items with a random gap drawn for each one. Every third
  // stretch of forty items runs with no gaps at all.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  function automatic int draw_send_gap();
    return ((items_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic bit next_ready();
    return pending_q.size() > 0 && (!pending_q[0].hold || reply_q.size() == 0);
  endfunction

  task automatic load_next();
    bridge_item_t it;
    it = pending_q.pop_front();
    action_i <= it.action;
    host_char_i <= it.host_char;
    start_ok_i <= it.start_ok;
    frame_id_i <= it.frame_id;
    frame_ext_i <= it.frame_ext;
    frame_rtr_i <= it.frame_rtr;
    frame_dlc_i <= it.frame_dlc;
    frame_data_i <= it.frame_data;
    timestamp_ms_i <= it.timestamp_ms;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int          g;
    bridge_item_t acc;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      acc = '{action_i, host_char_i, start_ok_i, frame_id_i, frame_ext_i,
              frame_rtr_i, frame_dlc_i, frame_data_i, timestamp_ms_i, 1'b0};
      predict_item(acc);
      items_sent++;
      g = draw_send_gap();
      if (g == 0 && next_ready()) begin
        load_next();
      end else begin
        in_valid_i <= 1'b0;
        send_gap <= g;
      end
    end else if (!in_valid_i) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (next_ready()) begin
        load_next();
        in_valid_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results under random stall and checks each against the
  // oldest expectation.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    int            s;
    bridge_reply_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("unexpected result: char %h tx %b", out_char_o, tx_frame_valid_o);
        error_count++;
      end else begin
        e = reply_q.pop_front();
        if (out_char_o !== e.out_char) begin
          $error("out_char expected %h actual %h", e.out_char, out_char_o); error_count++;
        end
        if (char_valid_o !== e.char_valid) begin
          $error("char_valid expected %b actual %b", e.char_valid, char_valid_o);
          error_count++;
        end
        if (tx_frame_valid_o !== e.tx_frame_valid) begin
          $error("tx_frame_valid expected %b actual %b", e.tx_frame_valid,
                 tx_frame_valid_o); error_count++;
        end
        if (tx_id_o !== e.tx_id) begin
          $error("tx_id expected %h actual %h", e.tx_id, tx_id_o); error_count++;
        end
        if (tx_ext_o !== e.tx_ext) begin
          $error("tx_ext expected %b actual %b", e.tx_ext, tx_ext_o); error_count++;
        end
        if (tx_rtr_o !== e.tx_rtr) begin
          $error("tx_rtr expected %b actual %b", e.tx_rtr, tx_rtr_o); error_count++;
        end
        if (tx_dlc_o !== e.tx_dlc) begin
          $error("tx_dlc expected %h actual %h", e.tx_dlc, tx_dlc_o); error_count++;
        end
        if (tx_data_o !== e.tx_data) begin
          $error("tx_data expected %h actual %h", e.tx_data, tx_data_o); error_count++;
        end
        if (start_request_o !== e.start_request) begin
          $error("start_request expected %b actual %b", e.start_request,
                 start_request_o); error_count++;
        end
        if (start_bitrate_o !== e.start_bitrate) begin
          $error("start_bitrate expected %h actual %h", e.start_bitrate,
                 start_bitrate_o); error_count++;
        end
        if (last_o !== e.last) begin
          $error("last expected %b actual %b", e.last, last_o); error_count++;
        end
      end
      s = ((replies_seen / 60) % 3 == 2) ? 0 : $urandom_range(0, 10);
      stall_left <= s;
      out_stall_i <= (s != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed part: commands refused while closed, setup, open with
    // timestamps, extreme frames in both directions, an echo, a tick and close.
    queue_line("O");
    queue_line("S9");
    queue_line("S8");
    queue_line("Z1");
    queue_line("O", 1'b0);
    queue_line("O");
    pending_q[$].hold = 1;
    queue_rx(29'h1fffffff, 1'b1, 1'b0, 4'd8, 64'hffffffffffffffff);
    queue_rx(29'h0000fabc, 1'b0, 1'b0, 4'd15, 64'h0123456789abcdef);
    queue_rx(29'h0, 1'b0, 1'b1, 4'd0, 64'h0);
    queue_line("T1FFFFFFF8FFFFFFFFFFFFFFFF");
    queue_line("t8000");
    queue_line("r7FF9");
    queue_simple(ActEcho);
    queue_simple(ActTick);
    queue_line("C");
    build_random(300);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i);
    wait (reply_q.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d items (host lines, received frames, echoes, ticks);",
             items_sent);
    $display("checked %0d results, %0d of them transmit frames.", replies_seen,
             frames_sent);
    if (error_count == 0 && reply_q.size() == 0) begin
      $display("tb_slcan_ascii_can_bridge passed");
    end else begin
      $display("tb_slcan_ascii_can_bridge failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_slcan_ascii_can_bridge failed");
    $finish;
  end

endmodule
